FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL; every use expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHECK_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define CHECK_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

FILE: rtl/brpsr_pkg.sv
package brpsr_pkg;

  typedef logic [31:0] word_t;

  // Operation codes carried on the input tuser
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_MRS   = 2'd2;
  localparam logic [1:0] OP_MSR   = 2'd3;

  // Mode field encodings
  localparam logic [4:0] MODE_USER       = 5'h10;
  localparam logic [4:0] MODE_FIQ        = 5'h11;
  localparam logic [4:0] MODE_IRQ        = 5'h12;
  localparam logic [4:0] MODE_SUPERVISOR = 5'h13;
  localparam logic [4:0] MODE_ABT        = 5'h17;
  localparam logic [4:0] MODE_UND        = 5'h1B;
  localparam logic [4:0] MODE_SYS        = 5'h1F;

  localparam word_t MASK_USER    = 32'hF80F_0200;
  localparam word_t MASK_PRIV    = 32'hF90F_03FF;
  localparam word_t STATUS_RESET = 32'h0000_0013;

  // Mode classes
  localparam logic [2:0] KIND_USER    = 3'd0;
  localparam logic [2:0] KIND_FIQ     = 3'd1;
  localparam logic [2:0] KIND_IRQ     = 3'd2;
  localparam logic [2:0] KIND_SVC     = 3'd3;
  localparam logic [2:0] KIND_ABT     = 3'd4;
  localparam logic [2:0] KIND_UND     = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd6;

  // Saved-word selection
  localparam logic [2:0] SEL_FIQ  = 3'd0;
  localparam logic [2:0] SEL_SVC  = 3'd2;
  localparam logic [2:0] SEL_NONE = 3'd5;

  localparam int LOW_REGS    = 8;
  localparam int HIGH_REGS   = 7;
  localparam int SAVED_WORDS = 5;
  localparam int PRIV_PAIRS  = 4;
  localparam int SHARED_HIGH = 5;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] reg_index;
    word_t      value;
    logic       use_saved;
    logic [3:0] field_mask;
  } item_t;

  function automatic logic [2:0] mode_kind(input logic [4:0] m);
    logic [2:0] k;
    unique case (m)
      MODE_USER, MODE_SYS: k = KIND_USER;
      MODE_FIQ:            k = KIND_FIQ;
      MODE_IRQ:            k = KIND_IRQ;
      MODE_SUPERVISOR:     k = KIND_SVC;
      MODE_ABT:            k = KIND_ABT;
      MODE_UND:            k = KIND_UND;
      default:             k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/banked_register_psr_unit.sv
// Channel  | Dir | Beat contents
// ---------+-----+-----------------------------------------------------------
// s_axis   | in  | tuser: operation; tdata: reg_index, value, use_saved, mask
// m_axis   | out | tdata: read_data; tuser: no_saved_word
//
// One beat in, one beat out. Each operation passes through an input register
// and then the result register before its result is on m_axis, and one
// operation is taken every cycle while the output is not stalled.
// All state updates (registers, banks, status words) land at the edge that
// moves the beat from the input register to the result register.
// Reset (rst, synchronous) clears every register and bank, puts the status
// word at supervisor mode and selects the supervisor saved word.
// A stall on m_axis holds the result register and the input register; the
// input side keeps taking beats while the input register is empty.
`include "assert_macros.svh"

module banked_register_psr_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] reg_index, [35:4] value, [36] use_saved, [40:37] field_mask, [47:41] zero
  input  logic [47:0] s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] read_data
  output logic [31:0] m_axis_tdata,
  // [0] no_saved_word
  output logic [0:0]  m_axis_tuser
);
  import brpsr_pkg::*;

  // Pipeline control
  logic  in_valid;
  item_t item;
  logic  advance;
  logic  fire;

  // Architectural state
  word_t      low_regs    [LOW_REGS];
  word_t      high_regs   [HIGH_REGS];
  word_t      user_bank   [HIGH_REGS];
  word_t      fiq_bank    [HIGH_REGS];
  word_t      priv_bank   [2*PRIV_PAIRS];
  word_t      saved_words [SAVED_WORDS];
  word_t      status;
  logic [2:0] sel;

  word_t      low_regs_next    [LOW_REGS];
  word_t      high_regs_next   [HIGH_REGS];
  word_t      user_bank_next   [HIGH_REGS];
  word_t      fiq_bank_next    [HIGH_REGS];
  word_t      priv_bank_next   [2*PRIV_PAIRS];
  word_t      saved_words_next [SAVED_WORDS];
  word_t      status_next;
  logic [2:0] sel_next;

  // Per-operation values
  logic [2:0] kind_cur;
  logic [2:0] kind_new;
  logic       have_saved;
  word_t      saved_rd;
  word_t      reg_rd;
  word_t      wmask;
  word_t      msr_status;
  logic       mode_change;
  word_t      rd;
  logic       none;
  logic       wr_en;
  word_t      wr_data;

  // Output register
  word_t out_data;
  logic  out_none;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign fire          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  assign m_axis_tdata    = out_data;
  assign m_axis_tuser[0] = out_none;

  assign kind_cur   = mode_kind(status[4:0]);
  assign have_saved = sel < SEL_NONE;

  always_comb begin
    saved_rd = '0;
    for (int i = 0; i < SAVED_WORDS; i++) begin
      if (sel == 3'(i)) saved_rd = saved_words[i];
    end
  end

  // Register read port: R0-R7 low, R8-R14 current high, R15 reads zero
  always_comb begin
    if (!item.reg_index[3]) begin
      reg_rd = low_regs[item.reg_index[2:0]];
    end else if (item.reg_index != 4'hF) begin
      reg_rd = high_regs[item.reg_index[2:0]];
    end else begin
      reg_rd = '0;
    end
  end

  // Status write mask narrowed by the byte-lane enables
  always_comb begin
    wmask = (status[4:0] == MODE_USER) ? MASK_USER : MASK_PRIV;
    wmask = wmask & {{8{item.field_mask[3]}}, {8{item.field_mask[2]}},
                     {8{item.field_mask[1]}}, {8{item.field_mask[0]}}};
  end

  assign msr_status  = (item.value & wmask) | (status & ~wmask);
  assign kind_new    = mode_kind(msr_status[4:0]);
  assign mode_change = (item.op == OP_MSR) && !item.use_saved &&
                       (msr_status[4:0] != status[4:0]);

  // Result and register write of this operation
  always_comb begin
    rd      = '0;
    none    = 1'b0;
    wr_en   = 1'b0;
    wr_data = item.value;
    unique case (item.op)
      OP_READ: begin
        rd = reg_rd;
      end
      OP_WRITE: begin
        wr_en = 1'b1;
      end
      OP_MRS: begin
        if (item.use_saved) begin
          rd   = have_saved ? saved_rd : '0;
          none = !have_saved;
        end else begin
          rd = status;
        end
        wr_en   = 1'b1;
        wr_data = rd;
      end
      OP_MSR: begin
        none = item.use_saved && !have_saved;
      end
      default: ;
    endcase
  end

  // Next state: register writes, status writes and the bank swap on a mode change
  always_comb begin
    low_regs_next    = low_regs;
    high_regs_next   = high_regs;
    user_bank_next   = user_bank;
    fiq_bank_next    = fiq_bank;
    priv_bank_next   = priv_bank;
    saved_words_next = saved_words;
    status_next      = status;
    sel_next         = sel;

    if (wr_en) begin
      if (!item.reg_index[3]) begin
        low_regs_next[item.reg_index[2:0]] = wr_data;
      end else if (item.reg_index != 4'hF) begin
        high_regs_next[item.reg_index[2:0]] = wr_data;
      end
    end

    if (item.op == OP_MSR) begin
      if (item.use_saved) begin
        for (int i = 0; i < SAVED_WORDS; i++) begin
          if (have_saved && sel == 3'(i)) begin
            saved_words_next[i] = (saved_rd & ~wmask) | (item.value & wmask);
          end
        end
      end else begin
        status_next = msr_status;
      end
    end

    if (mode_change) begin
      // Store the outgoing mode's banked registers
      if (kind_cur == KIND_USER) begin
        user_bank_next = high_regs;
      end else if (kind_cur == KIND_FIQ) begin
        fiq_bank_next = high_regs;
      end else if (kind_cur != KIND_UNKNOWN) begin
        for (int i = 0; i < SHARED_HIGH; i++) user_bank_next[i] = high_regs[i];
        for (int p = 0; p < PRIV_PAIRS; p++) begin
          if (kind_cur == 3'(p + 2)) begin
            priv_bank_next[2*p]     = high_regs[SHARED_HIGH];
            priv_bank_next[2*p + 1] = high_regs[SHARED_HIGH + 1];
          end
        end
      end
      // Load the incoming mode's banked registers from the stored copies
      if (kind_new == KIND_USER) begin
        high_regs_next = user_bank_next;
        sel_next       = SEL_NONE;
      end else if (kind_new == KIND_FIQ) begin
        high_regs_next = fiq_bank_next;
        sel_next       = SEL_FIQ;
      end else if (kind_new != KIND_UNKNOWN) begin
        for (int i = 0; i < SHARED_HIGH; i++) high_regs_next[i] = user_bank_next[i];
        for (int p = 0; p < PRIV_PAIRS; p++) begin
          if (kind_new == 3'(p + 2)) begin
            high_regs_next[SHARED_HIGH]     = priv_bank_next[2*p];
            high_regs_next[SHARED_HIGH + 1] = priv_bank_next[2*p + 1];
          end
        end
        sel_next = kind_new - 3'd1;
      end
    end
  end

  // Input register: take a beat whenever the stage is free or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      item.op         <= s_axis_tuser;
      item.reg_index  <= s_axis_tdata[3:0];
      item.value      <= s_axis_tdata[35:4];
      item.use_saved  <= s_axis_tdata[36];
      item.field_mask <= s_axis_tdata[40:37];
    end
  end

  // Result register: hold while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (fire) begin
      out_data <= rd;
      out_none <= none;
    end
  end

  // Architectural state: commit as the beat moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LOW_REGS; i++) low_regs[i] <= '0;
      for (int i = 0; i < HIGH_REGS; i++) begin
        high_regs[i] <= '0;
        user_bank[i] <= '0;
        fiq_bank[i]  <= '0;
      end
      for (int i = 0; i < 2*PRIV_PAIRS; i++) priv_bank[i] <= '0;
      for (int i = 0; i < SAVED_WORDS; i++) saved_words[i] <= '0;
      status <= STATUS_RESET;
      sel    <= SEL_SVC;
    end else if (fire) begin
      low_regs    <= low_regs_next;
      high_regs   <= high_regs_next;
      user_bank   <= user_bank_next;
      fiq_bank    <= fiq_bank_next;
      priv_bank   <= priv_bank_next;
      saved_words <= saved_words_next;
      status      <= status_next;
      sel         <= sel_next;
    end
  end

  `CHECK_IMPLY(a_user_no_saved, kind_cur == KIND_USER, sel == SEL_NONE, "user mode selects a saved word")
  `CHECK_IMPLY(a_fiq_saved_sel, kind_cur == KIND_FIQ, sel == SEL_FIQ, "FIQ mode selects wrong saved word")
  `CHECK_IMPLY(a_none_reads_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "missing saved word with nonzero data")
  `CHECK_NEXT(a_fire_gives_result, fire, m_axis_tvalid, "processed beat produced no result")
  `CHECK_IMPLY(a_stall_cause, !s_axis_tready, in_valid && m_axis_tvalid && !m_axis_tready, "input stalled without output stall")

endmodule
